// File: rtl/cau_pkg.sv
// Shared types, constants and helper functions for the complex arithmetic unit.
// No dependencies; every other file in rtl/ refers to this package by scoped name.
package cau_pkg;

   localparam int FRAC_BITS = 16;
   localparam int SHIFT     = 32 - FRAC_BITS;
   localparam int STEPS     = 32;

   localparam logic [63:0] HUGE_MAG  = 64'h1_FFFF_FFFF;
   localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF;
   localparam logic [63:0] NEG_LIMIT = 64'h8000_0000;
   localparam logic [63:0] HALF      = 64'd1 << (FRAC_BITS - 1);

   typedef enum logic [2:0] {
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CONJ, OP_RECIP, OP_MOD, OP_EQUAL
   } op_type;

   typedef struct packed {
      logic        valid;
      op_type      op;
      logic        neg_r;
      logic        neg_i;
      logic        eq;
      logic        dz;
      logic [63:0] mag_r;
      logic [63:0] mag_i;
   } meta_type;

   typedef struct packed {
      meta_type    meta;
      logic [63:0] den;
   } front_type;

   typedef struct packed {
      logic [31:0] quo;
      logic        huge;
      logic        rnd;
   } lane_type;

   typedef struct packed {
      logic [31:0] root;
      logic        inc;
   } root_type;

   // {overflow, value}
   function automatic logic [32:0] saturate(input logic neg, input logic [63:0] mag);
      logic [63:0] negm;
      logic [32:0] res;
      negm = 64'd0 - mag;
      if (neg) begin
         if (mag > NEG_LIMIT) res = {1'b1, 32'h8000_0000};
         else                 res = {1'b0, negm[31:0]};
      end else begin
         if (mag > POS_LIMIT) res = {1'b1, 32'h7FFF_FFFF};
         else                 res = {1'b0, mag[31:0]};
      end
      return res;
   endfunction

endpackage

// File: rtl/cau_front.sv
// Front end: operand products, signed sums and sign/magnitude split (three stages).
// Depends on cau_pkg.
module cau_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [135:0]        in_data,
   output cau_pkg::front_type  out
);

   cau_pkg::op_type    op_in;
   logic signed [31:0] ar, ai, br, bi, dr, di;
   logic signed [63:0] p1_in, p2_in, p3_in, p4_in, q1_in, q2_in;
   logic signed [32:0] lin_r_in, lin_i_in;
   logic               eq_in;

   logic               s1_valid_ff, s2_valid_ff, s3_valid_ff;
   cau_pkg::op_type    s1_op_ff, s2_op_ff, s3_op_ff;
   logic signed [63:0] p1_ff, p2_ff, p3_ff, p4_ff, q1_ff, q2_ff;
   logic signed [32:0] lin_r_ff, lin_i_ff;
   logic signed [31:0] ar_ff, ai_ff;
   logic               s1_eq_ff, s2_eq_ff, s3_eq_ff;

   logic signed [64:0] sr_r_in, sr_i_in, sr_r_ff, sr_i_ff;
   logic        [63:0] den_in, s2_den_ff, s3_den_ff;

   logic signed [64:0] abs_r, abs_i;
   logic        [63:0] mag_r_ff, mag_i_ff;
   logic               neg_r_ff, neg_i_ff, dz_ff;

   assign op_in = cau_pkg::op_type'(in_data[2:0]);
   assign ar    = signed'(in_data[34:3]);
   assign ai    = signed'(in_data[66:35]);
   assign br    = signed'(in_data[98:67]);
   assign bi    = signed'(in_data[130:99]);
   // reciprocal and modulus square the first operand
   assign dr    = (op_in == cau_pkg::OP_DIV) ? br : ar;
   assign di    = (op_in == cau_pkg::OP_DIV) ? bi : ai;

   assign p1_in = ar * br;
   assign p2_in = ai * bi;
   assign p3_in = ar * bi;
   assign p4_in = ai * br;
   assign q1_in = dr * dr;
   assign q2_in = di * di;
   assign eq_in = (op_in == cau_pkg::OP_EQUAL) && (ar == br) && (ai == bi);

   always_comb begin
      case (op_in)
         cau_pkg::OP_ADD: begin
            lin_r_in = 33'(ar) + 33'(br);
            lin_i_in = 33'(ai) + 33'(bi);
         end
         cau_pkg::OP_SUB: begin
            lin_r_in = 33'(ar) - 33'(br);
            lin_i_in = 33'(ai) - 33'(bi);
         end
         cau_pkg::OP_CONJ: begin
            lin_r_in = 33'(ar);
            lin_i_in = 33'sd0 - 33'(ai);
         end
         default: begin
            lin_r_in = '0;
            lin_i_in = '0;
         end
      endcase
   end

   always_comb begin
      case (s1_op_ff)
         cau_pkg::OP_MUL: begin
            sr_r_in = 65'(p1_ff) - 65'(p2_ff);
            sr_i_in = 65'(p3_ff) + 65'(p4_ff);
         end
         cau_pkg::OP_DIV: begin
            sr_r_in = 65'(p1_ff) + 65'(p2_ff);
            sr_i_in = 65'(p4_ff) - 65'(p3_ff);
         end
         cau_pkg::OP_RECIP: begin
            sr_r_in = 65'(ar_ff) <<< cau_pkg::FRAC_BITS;
            sr_i_in = 65'sd0 - (65'(ai_ff) <<< cau_pkg::FRAC_BITS);
         end
         cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_CONJ: begin
            sr_r_in = 65'(lin_r_ff);
            sr_i_in = 65'(lin_i_ff);
         end
         default: begin
            sr_r_in = '0;
            sr_i_in = '0;
         end
      endcase
   end

   // squares are nonnegative, at most 2^62
   assign den_in = {1'b0, q1_ff[62:0]} + {1'b0, q2_ff[62:0]};

   assign abs_r = sr_r_ff[64] ? (65'sd0 - sr_r_ff) : sr_r_ff;
   assign abs_i = sr_i_ff[64] ? (65'sd0 - sr_i_ff) : sr_i_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_op_ff  <= op_in;
         p1_ff     <= p1_in;
         p2_ff     <= p2_in;
         p3_ff     <= p3_in;
         p4_ff     <= p4_in;
         q1_ff     <= q1_in;
         q2_ff     <= q2_in;
         lin_r_ff  <= lin_r_in;
         lin_i_ff  <= lin_i_in;
         ar_ff     <= ar;
         ai_ff     <= ai;
         s1_eq_ff  <= eq_in;

         s2_op_ff  <= s1_op_ff;
         sr_r_ff   <= sr_r_in;
         sr_i_ff   <= sr_i_in;
         s2_den_ff <= den_in;
         s2_eq_ff  <= s1_eq_ff;

         s3_op_ff  <= s2_op_ff;
         neg_r_ff  <= sr_r_ff[64];
         neg_i_ff  <= sr_i_ff[64];
         mag_r_ff  <= abs_r[63:0];
         mag_i_ff  <= abs_i[63:0];
         s3_den_ff <= s2_den_ff;
         s3_eq_ff  <= s2_eq_ff;
         dz_ff     <= ((s2_op_ff == cau_pkg::OP_DIV) || (s2_op_ff == cau_pkg::OP_RECIP))
                      && (s2_den_ff == 64'd0);
      end
   end

   assign out.meta.valid = s3_valid_ff;
   assign out.meta.op    = s3_op_ff;
   assign out.meta.neg_r = neg_r_ff;
   assign out.meta.neg_i = neg_i_ff;
   assign out.meta.eq    = s3_eq_ff;
   assign out.meta.dz    = dz_ff;
   assign out.meta.mag_r = mag_r_ff;
   assign out.meta.mag_i = mag_i_ff;
   assign out.den        = s3_den_ff;

endmodule

// File: rtl/cau_div.sv
// Pipelined restoring divider, one quotient bit per stage, two lanes sharing a divisor.
// Carries the item's sideband along. Depends on cau_pkg.
module cau_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  cau_pkg::front_type  in,
   output cau_pkg::meta_type   meta_out,
   output cau_pkg::lane_type   lane_r,
   output cau_pkg::lane_type   lane_i
);

   localparam int N = cau_pkg::STEPS;

   logic [63:0]       rr_ff   [0:N];
   logic [63:0]       ri_ff   [0:N];
   logic [31:0]       lor_ff  [0:N];
   logic [31:0]       loi_ff  [0:N];
   logic [31:0]       qr_ff   [0:N];
   logic [31:0]       qi_ff   [0:N];
   logic [63:0]       den_ff  [0:N];
   logic              hr_ff   [0:N];
   logic              hi_ff   [0:N];
   cau_pkg::meta_type meta_ff [0:N];
   logic [N:0]        valid_ff;

   logic [63:0] r0_r, r0_i;

   // {quotient bit, new remainder}
   function automatic logic [64:0] div_step(input logic [63:0] r, input logic b,
                                            input logic [63:0] d);
      logic [64:0] t, sub;
      t   = {r, b};
      sub = t - {1'b0, d};
      if (t >= {1'b0, d}) return {1'b1, sub[63:0]};
      else                return {1'b0, t[63:0]};
   endfunction

   assign r0_r = in.meta.mag_r >> cau_pkg::SHIFT;
   assign r0_i = in.meta.mag_i >> cau_pkg::SHIFT;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[N-1:0], in.meta.valid};
      end
   end

   // quotient reaches 2^32 exactly when mag >> SHIFT is not below the divisor
   always_ff @(posedge clock) begin
      if (en) begin
         rr_ff[0]   <= r0_r;
         ri_ff[0]   <= r0_i;
         lor_ff[0]  <= {in.meta.mag_r[cau_pkg::SHIFT-1:0], {cau_pkg::FRAC_BITS{1'b0}}};
         loi_ff[0]  <= {in.meta.mag_i[cau_pkg::SHIFT-1:0], {cau_pkg::FRAC_BITS{1'b0}}};
         qr_ff[0]   <= '0;
         qi_ff[0]   <= '0;
         hr_ff[0]   <= r0_r >= in.den;
         hi_ff[0]   <= r0_i >= in.den;
         den_ff[0]  <= in.den;
         meta_ff[0] <= in.meta;
      end
   end

   for (genvar k = 1; k <= N; k++) begin : g_step
      logic [64:0] sr, si;
      assign sr = div_step(rr_ff[k-1], lor_ff[k-1][31], den_ff[k-1]);
      assign si = div_step(ri_ff[k-1], loi_ff[k-1][31], den_ff[k-1]);
      always_ff @(posedge clock) begin
         if (en) begin
            rr_ff[k]   <= sr[63:0];
            ri_ff[k]   <= si[63:0];
            qr_ff[k]   <= {qr_ff[k-1][30:0], sr[64]};
            qi_ff[k]   <= {qi_ff[k-1][30:0], si[64]};
            lor_ff[k]  <= {lor_ff[k-1][30:0], 1'b0};
            loi_ff[k]  <= {loi_ff[k-1][30:0], 1'b0};
            hr_ff[k]   <= hr_ff[k-1];
            hi_ff[k]   <= hi_ff[k-1];
            den_ff[k]  <= den_ff[k-1];
            meta_ff[k] <= meta_ff[k-1];
         end
      end
   end

   always_comb begin
      meta_out       = meta_ff[N];
      meta_out.valid = valid_ff[N];
   end

   assign lane_r.quo  = qr_ff[N];
   assign lane_r.huge = hr_ff[N];
   assign lane_r.rnd  = {rr_ff[N], 1'b0} >= {1'b0, den_ff[N]};
   assign lane_i.quo  = qi_ff[N];
   assign lane_i.huge = hi_ff[N];
   assign lane_i.rnd  = {ri_ff[N], 1'b0} >= {1'b0, den_ff[N]};

endmodule

// File: rtl/cau_sqrt.sv
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Stage count matches cau_div so results line up. Depends on cau_pkg.
module cau_sqrt (
   input  logic              clock,
   input  logic              en,
   input  logic [63:0]       value,
   output cau_pkg::root_type out
);

   localparam int N = cau_pkg::STEPS;

   logic [63:0] v_ff    [0:N];
   logic [33:0] rem_ff  [0:N];
   logic [31:0] root_ff [0:N];

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff[0]    <= value;
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
      end
   end

   for (genvar k = 1; k <= N; k++) begin : g_step
      logic [35:0] rs, t, d;
      assign rs = {rem_ff[k-1], v_ff[k-1][63:62]};
      assign t  = {2'b00, root_ff[k-1], 2'b01};
      assign d  = rs - t;
      always_ff @(posedge clock) begin
         if (en) begin
            v_ff[k] <= {v_ff[k-1][61:0], 2'b00};
            if (rs >= t) begin
               rem_ff[k]  <= d[33:0];
               root_ff[k] <= {root_ff[k-1][30:0], 1'b1};
            end else begin
               rem_ff[k]  <= rs[33:0];
               root_ff[k] <= {root_ff[k-1][30:0], 1'b0};
            end
         end
      end
   end

   // round to nearest: remainder above the root means v > s*s + s
   assign out.root = root_ff[N];
   assign out.inc  = rem_ff[N] > {2'b00, root_ff[N]};

endmodule

// File: rtl/complex_arithmetic_unit_core.sv
// Top level of the complex arithmetic unit: front end, divider, root, rounding, output.
// Depends on cau_pkg, cau_front, cau_div and cau_sqrt.
//
// Fully pipelined Q16.16 complex ALU: one transfer accepted per clock while the output
// is not stalled; each result passes three front stages, 33 divider/root stages,
// a rounding stage and the output register. All stages advance together: a stalled
// output holds the whole pipeline, so req_tready follows !rsp_tvalid || rsp_tready.
module complex_arithmetic_unit_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // operation[2:0], a_real[34:3], a_imag[66:35], b_real[98:67], b_imag[130:99]
   input  logic [135:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // res_real[31:0], res_imag[63:32], is_equal[64], div_zero[65], overflow[66]
   output logic [71:0]  rsp_tdata
);

   logic               en;
   cau_pkg::front_type front;
   cau_pkg::meta_type  meta;
   cau_pkg::lane_type  lane_r, lane_i;
   cau_pkg::root_type  root;

   logic [63:0] e_mag_r_in, e_mag_i_in;
   logic [63:0] e_mag_r_ff, e_mag_i_ff;
   logic        e_valid_ff, e_neg_r_ff, e_neg_i_ff, e_dz_ff, e_eq_ff;
   logic [32:0] sat_r, sat_i;
   logic        out_valid_ff;
   logic [71:0] out_data_ff;

   assign en         = !out_valid_ff || rsp_tready;
   assign req_tready = en;

   cau_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_tvalid),
      .in_data  (req_tdata),
      .out      (front)
   );

   cau_div u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in       (front),
      .meta_out (meta),
      .lane_r   (lane_r),
      .lane_i   (lane_i)
   );

   cau_sqrt u_sqrt (
      .clock (clock),
      .en    (en),
      .value (front.den),
      .out   (root)
   );

   always_comb begin
      case (meta.op)
         cau_pkg::OP_MUL: begin
            e_mag_r_in = (meta.mag_r + cau_pkg::HALF) >> cau_pkg::FRAC_BITS;
            e_mag_i_in = (meta.mag_i + cau_pkg::HALF) >> cau_pkg::FRAC_BITS;
         end
         cau_pkg::OP_DIV, cau_pkg::OP_RECIP: begin
            if (meta.dz) begin
               e_mag_r_in = '0;
               e_mag_i_in = '0;
            end else begin
               e_mag_r_in = lane_r.huge ? cau_pkg::HUGE_MAG
                                        : {32'd0, lane_r.quo} + 64'(lane_r.rnd);
               e_mag_i_in = lane_i.huge ? cau_pkg::HUGE_MAG
                                        : {32'd0, lane_i.quo} + 64'(lane_i.rnd);
            end
         end
         cau_pkg::OP_MOD: begin
            e_mag_r_in = {32'd0, root.root} + 64'(root.inc);
            e_mag_i_in = '0;
         end
         default: begin
            e_mag_r_in = meta.mag_r;
            e_mag_i_in = meta.mag_i;
         end
      endcase
   end

   assign sat_r = cau_pkg::saturate(e_neg_r_ff, e_mag_r_ff);
   assign sat_i = cau_pkg::saturate(e_neg_i_ff, e_mag_i_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         e_valid_ff   <= meta.valid;
         out_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_mag_r_ff  <= e_mag_r_in;
         e_mag_i_ff  <= e_mag_i_in;
         e_neg_r_ff  <= meta.neg_r;
         e_neg_i_ff  <= meta.neg_i;
         e_dz_ff     <= meta.dz;
         e_eq_ff     <= meta.eq;
         out_data_ff <= {5'd0, sat_r[32] | sat_i[32], e_dz_ff, e_eq_ff,
                         sat_i[31:0], sat_r[31:0]};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[65] |-> (rsp_tdata[63:0] == 64'd0) && !rsp_tdata[66])
      else $error("div_zero result not zero or flagged overflow");

   a_eq_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[64] |-> (rsp_tdata[63:0] == 64'd0) && !rsp_tdata[65]
                                      && !rsp_tdata[66])
      else $error("equal result carries data or other flags");

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output register");

endmodule

// File: tb/sv/complex_arithmetic_unit_core_tb.sv
// Self-checking testbench for the complex arithmetic unit: directed corner items, then
// random bursts, with a bit-exact Q16.16 predictor and a result scoreboard.
// Depends on cau_pkg and complex_arithmetic_unit_core.
module complex_arithmetic_unit_core_tb;

   typedef struct packed {
      logic [31:0] res_real;
      logic [31:0] res_imag;
      logic        is_equal;
      logic        div_zero;
      logic        overflow;
   } cplx_result_type;

   class cplx_scoreboard;
      cplx_result_type pending_q[$];
      int              errors = 0;

      function void note_input(cplx_result_type exp_res);
         pending_q.push_back(exp_res);
      endfunction

      function void check_result(logic [71:0] data);
         cplx_result_type exp_res;
         if (pending_q.size() == 0) begin
            $error("result 0x%h arrived with nothing expected", data);
            errors++;
            return;
         end
         exp_res = pending_q.pop_front();
         if (data[31:0] !== exp_res.res_real) begin
            $error("res_real: expected %h actual %h", exp_res.res_real, data[31:0]);
            errors++;
         end
         if (data[63:32] !== exp_res.res_imag) begin
            $error("res_imag: expected %h actual %h", exp_res.res_imag, data[63:32]);
            errors++;
         end
         if (data[64] !== exp_res.is_equal) begin
            $error("is_equal: expected %b actual %b", exp_res.is_equal, data[64]);
            errors++;
         end
         if (data[65] !== exp_res.div_zero) begin
            $error("div_zero: expected %b actual %b", exp_res.div_zero, data[65]);
            errors++;
         end
         if (data[66] !== exp_res.overflow) begin
            $error("overflow: expected %b actual %b", exp_res.overflow, data[66]);
            errors++;
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [135:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [71:0]  rsp_tdata;

   cplx_scoreboard sb;
   bit             hold_request;
   bit             stim_done;

   complex_arithmetic_unit_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // ---------------- Q16.16 predictor ----------------
   function automatic longint unsigned magnitude(longint p);
      return p < 0 ? longint'(-p) : longint'(p);
   endfunction

   // exact signed sum as sign and magnitude
   function automatic bit signed_sum(longint p, longint q, output longint unsigned m);
      longint unsigned mp, mq;
      mp = magnitude(p);
      mq = magnitude(q);
      if ((p < 0) == (q < 0)) begin
         m = mp + mq;
         return (p < 0) && m != 0;
      end
      if (mp >= mq) begin
         m = mp - mq;
         return (p < 0) && m != 0;
      end
      m = mq - mp;
      return q < 0;
   endfunction

   function automatic logic [31:0] clamp32(bit neg, longint unsigned m, inout bit ovf);
      longint unsigned lim;
      lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      if (m > lim) begin
         m = lim;
         ovf = 1;
      end
      return neg ? 32'(64'd0 - m) : 32'(m);
   endfunction

   function automatic longint unsigned frac_quotient(longint unsigned m, longint unsigned d);
      longint unsigned q, r;
      q = m / d;
      r = m % d;
      if ((q >> (32 - cau_pkg::FRAC_BITS)) != 0) return 64'h1_FFFF_FFFF;
      for (int i = 0; i < cau_pkg::FRAC_BITS; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= d) begin
            r = r - d;
            q = q | 1;
         end
      end
      if ((r << 1) >= d) q = q + 1;
      return q;
   endfunction

   function automatic longint unsigned rounded_root(longint unsigned v);
      longint unsigned res, bitv, rem;
      res = 0;
      bitv = 64'd1 << 62;
      rem = v;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= res + bitv) begin
            rem = rem - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      if (rem > res) res = res + 1;
      return res;
   endfunction

   function automatic void complex_quotient(longint nr, longint ni, longint dr, longint di,
                                            inout cplx_result_type r);
      longint unsigned den, m;
      bit ovf, neg;
      ovf = 0;
      den = magnitude(dr * dr) + magnitude(di * di);
      if (den == 0) begin
         r.div_zero = 1;
         return;
      end
      neg = signed_sum(nr * dr, ni * di, m);
      r.res_real = clamp32(neg, frac_quotient(m, den), ovf);
      neg = signed_sum(ni * dr, -(nr * di), m);
      r.res_imag = clamp32(neg, frac_quotient(m, den), ovf);
      r.overflow = ovf;
   endfunction

   function automatic logic [31:0] product_part(longint p, longint q, inout bit ovf);
      longint unsigned m;
      bit neg;
      neg = signed_sum(p, q, m);
      m = (m + (64'd1 << (cau_pkg::FRAC_BITS - 1))) >> cau_pkg::FRAC_BITS;
      return clamp32(neg, m, ovf);
   endfunction

   function automatic logic [31:0] wrap_clamp(longint v, inout bit ovf);
      return clamp32(v < 0, magnitude(v), ovf);
   endfunction

   function automatic cplx_result_type predict_result(cau_pkg::op_type op,
                                                      logic signed [31:0] ar32,
                                                      logic signed [31:0] ai32,
                                                      logic signed [31:0] br32,
                                                      logic signed [31:0] bi32);
      cplx_result_type r;
      longint ar, ai, br, bi;
      bit ovf;
      r = '0;
      ovf = 0;
      ar = ar32;
      ai = ai32;
      br = br32;
      bi = bi32;
      case (op)
         cau_pkg::OP_ADD: begin
            r.res_real = wrap_clamp(ar + br, ovf);
            r.res_imag = wrap_clamp(ai + bi, ovf);
         end
         cau_pkg::OP_SUB: begin
            r.res_real = wrap_clamp(ar - br, ovf);
            r.res_imag = wrap_clamp(ai - bi, ovf);
         end
         cau_pkg::OP_MUL: begin
            r.res_real = product_part(ar * br, -(ai * bi), ovf);
            r.res_imag = product_part(ar * bi, ai * br, ovf);
         end
         cau_pkg::OP_DIV:   complex_quotient(ar, ai, br, bi, r);
         cau_pkg::OP_CONJ: begin
            r.res_real = wrap_clamp(ar, ovf);
            r.res_imag = wrap_clamp(-ai, ovf);
         end
         cau_pkg::OP_RECIP:
            complex_quotient(longint'(1) << cau_pkg::FRAC_BITS, 0, ar, ai, r);
         cau_pkg::OP_MOD:
            r.res_real = clamp32(0, rounded_root(magnitude(ar * ar) + magnitude(ai * ai)),
                                 ovf);
         default:  r.is_equal = (ar == br) && (ai == bi);
      endcase
      if (op != cau_pkg::OP_DIV && op != cau_pkg::OP_RECIP) r.overflow = ovf;
      return r;
   endfunction

   // ---------------- clock, reset, limit ----------------
   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      #100_000_000;
      $display("Mismatches found");
      $finish;
   end

   // ---------------- sender ----------------
   int burst_left;

   task automatic send_item(cau_pkg::op_type op, logic [31:0] ar, logic [31:0] ai,
                            logic [31:0] br, logic [31:0] bi);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 30);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, bi, br, ai, ar, op};
      do @(posedge clock); while (!req_tready);
      sb.note_input(predict_result(op, ar, ai, br, bi));
      burst_left--;
   endtask

   function automatic logic [31:0] random_operand();
      case ($urandom_range(0, 5))
         0:       return $urandom();
         1:       return 32'($signed($urandom_range(0, 32'h7FFFF)) - 32'sh40000);
         2:       return 32'($signed($urandom_range(0, 2047)) - 1024);
         3: begin
            case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         default: return 32'($signed($urandom_range(0, 32'h1FF_FFFF)) - 32'sh100_0000);
      endcase
   endfunction

   // ---------------- receiver ----------------
   initial begin
      int cyc;
      rsp_tready = 1'b0;
      cyc = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
         cyc++;
         if (hold_request) begin
            // long hold-off: pipeline fills and backs up into the input
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_request = 0;
            rsp_tready <= 1'b1;
         end else begin
            case ((cyc / 97) % 4)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= (cyc % 4) != 0;
               2:       rsp_tready <= $urandom_range(0, 1);
               default: rsp_tready <= (cyc % 7) < 2;
            endcase
         end
      end
   end

   // ---------------- main stimulus ----------------
   initial begin
      logic [31:0] ar, ai, br, bi;
      cau_pkg::op_type op;
      sb = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      burst_left = 0;
      hold_request = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed corners
      send_item(cau_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF);
      send_item(cau_pkg::OP_ADD, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000);
      send_item(cau_pkg::OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
      send_item(cau_pkg::OP_SUB, 32'h0005_0000, 32'h0, 32'h0002_8000, 32'h0001_0000);
      send_item(cau_pkg::OP_MUL, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 32'hFFFB_0000);
      send_item(cau_pkg::OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      send_item(cau_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      // tie rounding
      send_item(cau_pkg::OP_MUL, 32'h0000_0001, 32'h0, 32'h0000_8000, 32'h0);
      send_item(cau_pkg::OP_MUL, 32'hFFFF_FFFF, 32'h0, 32'h0000_8000, 32'h0);
      // zero divisor
      send_item(cau_pkg::OP_DIV, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0);
      send_item(cau_pkg::OP_DIV, 32'h0004_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000);
      send_item(cau_pkg::OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0);
      send_item(cau_pkg::OP_DIV, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
      // negated minimum saturates
      send_item(cau_pkg::OP_CONJ, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
      send_item(cau_pkg::OP_CONJ, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h0);
      // zero divisor
      send_item(cau_pkg::OP_RECIP, 32'h0, 32'h0, 32'h0, 32'h0);
      send_item(cau_pkg::OP_RECIP, 32'h0000_0001, 32'h0, 32'h0, 32'h0);
      send_item(cau_pkg::OP_RECIP, 32'h0002_0000, 32'hFFFE_0000, 32'h0, 32'h0);
      send_item(cau_pkg::OP_RECIP, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0);
      send_item(cau_pkg::OP_MOD, 32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0);
      // above limit
      send_item(cau_pkg::OP_MOD, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
      send_item(cau_pkg::OP_MOD, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(cau_pkg::OP_EQUAL, 32'h1234_5678, 32'h8000_0000, 32'h1234_5678, 32'h8000_0000);
      send_item(cau_pkg::OP_EQUAL, 32'h1234_5678, 32'h8000_0000, 32'h1234_5678, 32'h8000_0001);
      send_item(cau_pkg::OP_EQUAL, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF);

      for (int n = 0; n < 2000; n++) begin
         if (n == 600) hold_request = 1;
         if (n == 1200) begin
            // drain completely before continuing
            req_tvalid <= 1'b0;
            while (sb.pending_q.size() != 0) @(posedge clock);
            burst_left = 1;
         end
         op = cau_pkg::op_type'($urandom_range(0, 7));
         ar = random_operand();
         ai = random_operand();
         br = random_operand();
         bi = random_operand();
         if (op == cau_pkg::OP_EQUAL && $urandom_range(0, 1)) begin
            br = ar;
            bi = ($urandom_range(0, 2) == 0) ? ai ^ (32'd1 << $urandom_range(0, 31)) : ai;
         end
         if ((op == cau_pkg::OP_DIV || op == cau_pkg::OP_RECIP)
             && $urandom_range(0, 15) == 0) begin
            br = 0;
            bi = 0;
            if (op == cau_pkg::OP_RECIP) begin
               ar = 0;
               ai = 0;
            end
         end
         send_item(op, ar, ai, br, bi);
      end
      req_tvalid <= 1'b0;

      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (sb.errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
